### src/lfbq_pkg.sv
// Shared types, codes and helpers for the line framing byte queue.
`default_nettype none

package lfbq_pkg;

    // Default number of bytes the ring store holds.
    localparam int CAPACITY_DEF = 4096;

    // Depth of the request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths of the request and result channels.
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 3;
    localparam int LINE_W   = 7;

    // Request kinds as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IGNORE  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LINE_BYTE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_LINE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISCARDED = 3'd4;

    // Longest line ever returned, terminator included, and its reset value.
    localparam logic [LINE_W-1:0] LINE_LIMIT   = 7'd64;
    localparam logic [LINE_W-1:0] MAX_LINE_RST = 7'd64;

    // Line terminators.
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    // Register index of max_line on the configuration port.
    localparam logic REG_MAX_LINE = 1'b0;

    // A classified request as it travels through the request queue.
    typedef struct packed {
        logic [KIND_W-1:0]  op;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    function automatic logic is_term(input logic [BYTE_W-1:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

### src/lfbq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lfbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/lfbq_front.sv
// Front end: accepts requests, classifies them and queues the ones with work.
`default_nettype none

module lfbq_front import lfbq_pkg::*; (
    input  wire logic               i_valid,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [BYTE_W-1:0]  i_data,
    input  wire logic [COUNT_W-1:0] i_count,
    output logic                    o_stall,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    logic w_has_work;

    // Unknown kinds are taken and dropped here; they produce no result.
    always_comb begin
        case (i_kind)
            KIND_PUSH, KIND_LINE, KIND_DISCARD: w_has_work = 1'b1;
            default:                            w_has_work = 1'b0;
        endcase
    end

    assign o_stall     = i_q_full;
    assign o_push      = i_valid && !i_q_full && w_has_work;
    assign o_cmd.op    = i_kind;
    assign o_cmd.data  = (i_kind == KIND_PUSH) ? i_data : '0;
    assign o_cmd.count = (i_kind == KIND_DISCARD) ? i_count : '0;

endmodule

`default_nettype wire

### src/lfbq_cmd_queue.sv
// Small request queue that decouples the front end from the back end.
`default_nettype none

module lfbq_cmd_queue import lfbq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_fill, n_fill;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_fill == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd];

endmodule

`default_nettype wire

### src/lfbq_back.sv
// Back end: carries out queued requests on the ring store and drives results.
`default_nettype none

module lfbq_back import lfbq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [LINE_W-1:0]           i_max_line,
    input  wire logic                        i_q_valid,
    input  wire t_cmd                        i_q_cmd,
    output logic                             o_q_pop,
    output logic                             o_ram_we,
    output logic      [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic      [BYTE_W-1:0]           o_ram_wdata,
    output logic                             o_ram_re,
    output logic      [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  wire logic [BYTE_W-1:0]           i_ram_rdata,
    output logic                             o_valid,
    output logic      [STATUS_W-1:0]         o_status,
    output logic      [BYTE_W-1:0]           o_data_res,
    output logic                             o_last,
    input  wire logic                        i_stall
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LEAD_RD  = 3'd1;
    localparam logic [2:0] S_LEAD_CHK = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_OUT = 3'd6;
    localparam logic [2:0] S_NO_LINE  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [PW-1:0]       r_rp, n_rp;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [LINE_W-1:0]   r_idx, n_idx;
    logic [LINE_W-1:0]   r_len, n_len;
    logic                r_ov, n_ov;
    logic [STATUS_W-1:0] r_ostat, n_ostat;
    logic [BYTE_W-1:0]   r_odata, n_odata;
    logic                r_olast, n_olast;

    logic                w_slot_free;
    logic                w_full;
    logic [PW-1:0]       w_rp_inc;
    logic [LINE_W-1:0]   w_limit;
    logic [LINE_W-1:0]   w_span;
    logic [CW-1:0]       w_drop_n;
    logic [MW-1:0]       w_req_ext;
    logic [MW-1:0]       w_cnt_ext;

    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= CAP_S) begin
            sum = sum - CAP_S;
        end
        return sum[PW-1:0];
    endfunction

    assign w_slot_free = !r_ov || !i_stall;
    assign w_full      = (r_cnt == CW'(CAPACITY));
    assign w_rp_inc    = (r_rp == PW'(CAPACITY - 1)) ? '0 : r_rp + 1'b1;
    assign w_limit     = (i_max_line > LINE_LIMIT) ? LINE_LIMIT : i_max_line;
    assign w_span      = (r_cnt < CW'(w_limit)) ? r_cnt[LINE_W-1:0] : w_limit;
    assign w_req_ext   = MW'(i_q_cmd.count);
    assign w_cnt_ext   = MW'(r_cnt);
    assign w_drop_n    = (w_req_ext < w_cnt_ext) ? w_req_ext[CW-1:0] : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_len       = r_len;
        n_ov        = r_ov && i_stall;
        n_ostat     = r_ostat;
        n_odata     = r_odata;
        n_olast     = r_olast;
        o_q_pop     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = ring_add(r_rp, r_cnt);
        o_ram_wdata = i_q_cmd.data;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rp;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        KIND_PUSH: begin
                            if (w_slot_free) begin
                                o_q_pop = 1'b1;
                                n_ov    = 1'b1;
                                n_odata = '0;
                                n_olast = 1'b1;
                                if (w_full) begin
                                    n_ostat = ST_FULL;
                                end else begin
                                    n_ostat  = ST_PUSHED;
                                    o_ram_we = 1'b1;
                                    n_cnt    = r_cnt + 1'b1;
                                end
                            end
                        end
                        KIND_DISCARD: begin
                            if (w_slot_free) begin
                                o_q_pop = 1'b1;
                                n_rp    = ring_add(r_rp, w_drop_n);
                                n_cnt   = r_cnt - w_drop_n;
                                n_ov    = 1'b1;
                                n_ostat = ST_DISCARDED;
                                n_odata = '0;
                                n_olast = 1'b1;
                            end
                        end
                        KIND_LINE: begin
                            o_q_pop = 1'b1;
                            n_state = S_LEAD_RD;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LEAD_RD: begin
                if (r_cnt == '0) begin
                    n_state = S_NO_LINE;
                end else begin
                    o_ram_re = 1'b1;
                    n_state  = S_LEAD_CHK;
                end
            end
            S_LEAD_CHK: begin
                if (is_term(i_ram_rdata)) begin
                    n_rp    = w_rp_inc;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_LEAD_RD;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= w_span) begin
                    n_state = S_NO_LINE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = ring_add(r_rp, CW'(r_idx));
                    n_state     = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (is_term(i_ram_rdata)) begin
                    n_len   = r_idx + 1'b1;
                    n_state = S_EMIT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT_RD: begin
                o_ram_re = 1'b1;
                n_state  = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (w_slot_free) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_LINE_BYTE;
                    n_odata = i_ram_rdata;
                    n_olast = (r_len == LINE_W'(1));
                    n_rp    = w_rp_inc;
                    n_cnt   = r_cnt - 1'b1;
                    n_len   = r_len - 1'b1;
                    n_state = (r_len == LINE_W'(1)) ? S_IDLE : S_EMIT_RD;
                end
            end
            S_NO_LINE: begin
                if (w_slot_free) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_NO_LINE;
                    n_odata = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostat <= n_ostat;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_valid    = r_ov;
    assign o_status   = r_ostat;
    assign o_data_res = r_odata;
    assign o_last     = r_olast;

endmodule

`default_nettype wire

### src/line_framing_byte_queue.sv
// Top level of the line framing byte queue: ring store with CR/LF line extraction.
//
// Requests enter on i_valid/o_stall with i_kind, i_data and i_count; a request is
// taken at a rising edge where i_valid is high and o_stall is low. Results leave on
// o_valid/i_stall with o_status, o_data_res and o_last; each request ends with a
// result carrying o_last, except the unused fourth kind, which is taken silently.
// A front end classifies requests into a two-entry queue, so requests keep being
// taken while the back end works or while a finished result waits for the receiver.
// A push or a discard is queued at its accepting edge and then carried out by the
// back end; pushes and discards can follow one per cycle while the receiver does
// not stall. A take-line request drops each leading terminator, scans bytes and
// emits each line byte with a read state and then a check or output state, as the
// store has one registered read port. While the receiver stalls, the result
// register holds its value and the back end waits before its next result; once the
// queue fills, o_stall rises. Reset clears the pointers, the fill count, the queue
// and max_line (to 64); the byte store needs no clearing pass, as only bytes that
// were pushed are ever read back. max_line is written on the APB-style port at byte
// address zero; the user must write it only while idle, as the block does not check.
`default_nettype none

module line_framing_byte_queue import lfbq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [BYTE_W-1:0]   i_data,
    input  wire logic [COUNT_W-1:0]  i_count,
    // Result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [BYTE_W-1:0]   o_data_res,
    output logic                     o_last,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int PW = $clog2(CAPACITY);

    logic [LINE_W-1:0] r_max_line;

    logic          w_q_push;
    t_cmd          w_q_in;
    logic          w_q_full;
    logic          w_q_valid;
    t_cmd          w_q_head;
    logic          w_q_pop;

    logic              w_ram_we;
    logic [PW-1:0]     w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [PW-1:0]     w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;

    // Configuration register: the write completes in the access phase.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= MAX_LINE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_LINE)) begin
            r_max_line <= pwdata[LINE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_LINE) ? 32'(r_max_line) : '0;

    // The front end takes requests and classifies them.
    lfbq_front u_front (
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_data   (i_data),
        .i_count  (i_count),
        .o_stall  (o_stall),
        .i_q_full (w_q_full),
        .o_push   (w_q_push),
        .o_cmd    (w_q_in)
    );

    // The queue lets the front keep taking requests while the back is busy.
    lfbq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_head),
        .i_pop   (w_q_pop)
    );

    // The back end owns the ring pointers, the scan sequencer and the result register.
    lfbq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_line  (r_max_line),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data_res  (o_data_res),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

    // The byte store itself.
    lfbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire

### src/lfbq_checker.sv
// Port-level checks for the line framing byte queue, bound to the top level.
`default_nettype none

module lfbq_checker import lfbq_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [BYTE_W-1:0]   o_data_res,
    input wire logic                o_last
);

    // The result register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)
                                  && $stable(o_data_res) && $stable(o_last)))
        else $error("stalled result changed");

    // Only defined status codes are ever shown.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_PUSHED || o_status == ST_FULL
                     || o_status == ST_LINE_BYTE || o_status == ST_NO_LINE
                     || o_status == ST_DISCARDED))
        else $error("undefined status code");

    // Every result other than a line byte is a single, final, empty result.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_LINE_BYTE) |-> (o_last && o_data_res == '0))
        else $error("non-line result not final or carries data");

    // A line byte that is not the last one is never a terminator.
    a_line_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_LINE_BYTE && !o_last) |-> !is_term(o_data_res))
        else $error("terminator inside a line");

endmodule

bind line_framing_byte_queue lfbq_checker u_lfbq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_data_res (o_data_res),
    .o_last     (o_last)
);

`default_nettype wire

### tb/sv/line_framing_byte_queue_tb.sv
// Self-checking testbench for the line framing byte queue: predictor, stimulus and checks.
`timescale 1ns / 1ps

module line_framing_byte_queue_tb;
    import lfbq_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    // Cycles allowed after the last result so that a silent request can finish.
    localparam int SETTLE_CYCLES   = 24;
    // Cycles in a row with no transfer on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 168;
    localparam int RANDOM_PHASES   = 6;
    localparam int MAX_PRINTED     = 40;

    // Register i sits at byte address 4*i; index one has no register behind it.
    localparam logic [2:0] ADDR_MAX_LINE = 3'(REG_MAX_LINE) << 2;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [BYTE_W-1:0]   i_data;
    logic [COUNT_W-1:0]  i_count;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_data_res;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    line_framing_byte_queue u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_data     (i_data),
        .i_count    (i_count),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data_res (o_data_res),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // One result as the block should deliver it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } t_queue_result;

    // Results still owed by the block, oldest first.
    t_queue_result pending_results[$];

    // The testbench's own copy of the ring store, its pointers and the line limit.
    logic [BYTE_W-1:0] ring_bytes [CAPACITY_DEF];
    int unsigned       ring_front;
    int unsigned       ring_fill;
    logic [LINE_W-1:0] line_max;

    int mismatches  = 0;
    int idle_cycles = 0;
    // Idling controls: the sender and receiver pause at random only when enabled.
    bit tx_pauses;
    bit rx_pauses;
    // A long receiver hold-off, counted down by the receiver process itself.
    int rx_hold = 0;
    int rx_gap  = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic bit is_eol(input logic [BYTE_W-1:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        return b;
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        logic [COUNT_W-1:0] c;
        c = COUNT_W'($urandom);
        return c;
    endfunction

    // Any byte that does not end a line.
    function automatic logic [BYTE_W-1:0] ordinary_byte();
        logic [BYTE_W-1:0] b;
        do b = random_byte(); while (is_eol(b));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_terminator();
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    // Mostly short lines, so that many are taken; now and then one that overruns the limit.
    function automatic int line_length(input int limit);
        if ($urandom_range(0, 99) < 70)
            return $urandom_range(1, ((limit < 12) ? limit : 12) + 1);
        return $urandom_range(1, limit + 4);
    endfunction

    function automatic logic [COUNT_W-1:0] discard_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return COUNT_W'($urandom_range(0, 6));
        if (r < 95)
            return COUNT_W'($urandom_range(0, 40));
        return COUNT_W'($urandom_range(0, 8191));
    endfunction

    // Sender gap before a request: mostly none, sometimes short, rarely long.
    function automatic int tx_gap();
        int r;
        if (!tx_pauses)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] ring_at(input int unsigned offset);
        return ring_bytes[(ring_front + offset) % CAPACITY_DEF];
    endfunction

    // Removes up to n bytes from the front; a larger n simply empties the store.
    function automatic void ring_drop(input int unsigned n);
        if (n > ring_fill)
            n = ring_fill;
        ring_front = (ring_front + n) % CAPACITY_DEF;
        ring_fill  = ring_fill - n;
    endfunction

    function automatic void add_pending(input logic [STATUS_W-1:0] status,
                                        input logic [BYTE_W-1:0] data, input logic last);
        pending_results.push_back('{status, data, last});
    endfunction

    // Applies one accepted request to the store and queues the results it must cause.
    function automatic void apply_request(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [COUNT_W-1:0] count);
        int unsigned limit;
        int unsigned span;
        int unsigned pos;
        bit          found;
        case (kind)
            KIND_PUSH: begin
                if (ring_fill >= CAPACITY_DEF) begin
                    add_pending(ST_FULL, '0, 1'b1);
                end else begin
                    ring_bytes[(ring_front + ring_fill) % CAPACITY_DEF] = data;
                    ring_fill++;
                    add_pending(ST_PUSHED, '0, 1'b1);
                end
            end
            KIND_LINE: begin
                // A limit above the hard ceiling behaves as the ceiling.
                limit = (line_max > LINE_LIMIT) ? LINE_LIMIT : line_max;
                // Leading terminators go, whether or not a line is found afterwards.
                while (ring_fill > 0 && is_eol(ring_at(0)))
                    ring_drop(1);
                span  = (ring_fill < limit) ? ring_fill : limit;
                pos   = 0;
                found = 1'b0;
                while (pos < span && !found) begin
                    if (is_eol(ring_at(pos)))
                        found = 1'b1;
                    else
                        pos++;
                end
                if (!found) begin
                    add_pending(ST_NO_LINE, '0, 1'b1);
                end else begin
                    for (int unsigned k = 0; k <= pos; k++)
                        add_pending(ST_LINE_BYTE, ring_at(k), k == pos);
                    ring_drop(pos + 1);
                end
            end
            KIND_DISCARD: begin
                ring_drop(count);
                add_pending(ST_DISCARDED, '0, 1'b1);
            end
            default: begin
                // The spare kind is taken and dropped without a result.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Every result taken by the receiver is held against the oldest outstanding one.
    always @(posedge i_clk) begin : check_results
        t_queue_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding: status %0d data %02h last %0b",
                                          o_status, o_data_res, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_data_res !== want.data ||
                    o_last !== want.last)
                    report_mismatch($sformatf("got status %0d data %02h last %0b, want %0d %02h %0b",
                                              o_status, o_data_res, o_last,
                                              want.status, want.data, want.last));
            end
        end
    end

    // The watchdog restarts whenever either channel moves; a hung block ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls at random, or for a long stretch when a hold-off is asked for.
    // ------------------------------------------------------------------

    initial begin : receiver
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0)
                rx_hold--;
            else if (rx_gap > 0)
                rx_gap--;
            else if (rx_pauses && $urandom_range(0, 3) == 0)
                rx_gap = stall_length();
            i_stall <= (rx_hold > 0) || (rx_gap > 0);
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration port
    // ------------------------------------------------------------------

    // Offers one request and returns once it has been taken. Valid stays high afterwards,
    // so back-to-back requests never lower and raise it within one time step.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                                input logic [COUNT_W-1:0] count);
        int gap;
        gap = tx_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_data  <= data;
        i_count <= count;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        apply_request(kind, data, count);
    endtask

    task automatic take_line();
        send_request(KIND_LINE, random_byte(), random_count());
    endtask

    task automatic discard(input logic [COUNT_W-1:0] n);
        send_request(KIND_DISCARD, random_byte(), n);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        send_request(KIND_PUSH, b, random_count());
    endtask

    // Pushes len bytes: ordinary ones, then the given terminator.
    task automatic send_line(input int len, input logic [BYTE_W-1:0] term);
        for (int i = 0; i < len - 1; i++)
            push_byte(ordinary_byte());
        push_byte(term);
    endtask

    // Stops offering requests and waits until every outstanding result has arrived.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: a setup cycle, then an access cycle that ends when pready is high.
    task automatic apb_access(input bit is_write, input logic [2:0] addr,
                              input logic [31:0] value, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (is_write && addr == ADDR_MAX_LINE)
            line_max = value[LINE_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_max_line();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_MAX_LINE, '0, rdata);
        if (rdata[LINE_W-1:0] !== line_max)
            report_mismatch($sformatf("max_line reads %0d, want %0d",
                                      rdata[LINE_W-1:0], line_max));
    endtask

    // Writes max_line, sometimes with junk in the unused upper bits, and reads it back.
    task automatic write_max_line(input logic [LINE_W-1:0] value);
        logic [31:0] word;
        logic [31:0] rdata;
        word = $urandom;
        word[LINE_W-1:0] = value;
        if ($urandom_range(0, 1))
            word[31:LINE_W] = '0;
        apb_access(1'b1, ADDR_MAX_LINE, word, rdata);
        check_max_line();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short directed sequence: byte extremes, every kind and the corner cases of take-line.
    task automatic test_directed_requests();
        tx_pauses = 1'b1;
        rx_pauses = 1'b1;
        // A line holding both byte extremes, closed by CR.
        push_byte(8'h00);
        send_request(KIND_PUSH, 8'hFF, 13'h1FFF);
        push_byte(8'h41);
        push_byte(CH_CR);
        take_line();
        // Nothing stored at all.
        take_line();
        // Only terminators: they are all dropped and the store empties.
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        take_line();
        // A leading LF is dropped before the line is found.
        push_byte(CH_LF);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(CH_LF);
        take_line();
        // CR LF: the line ends at the CR, and the LF is swept up by the next take.
        push_byte(8'h61);
        push_byte(CH_CR);
        push_byte(CH_LF);
        take_line();
        take_line();
        // An unterminated byte stays put; a zero discard changes nothing.
        push_byte(8'h55);
        take_line();
        discard('0);
        take_line();
        send_request(KIND_IGNORE, 8'hFF, 13'h1FFF);
        // An oversized discard is clamped to what is stored.
        discard(13'h1FFF);
        send_request(KIND_LINE, 8'hFF, 13'h1FFF);
        wait_for_results();
    endtask

    // Line length against max_line: the ceiling, zero, one, an exact fit, and a stray address.
    task automatic test_line_length_limits();
        logic [31:0] rdata;
        tx_pauses = 1'b1;
        rx_pauses = 1'b1;
        // Above the ceiling behaves as 64: a 64-byte line passes, a 65-byte one never does.
        write_max_line(7'd127);
        send_line(64, CH_LF);
        take_line();
        send_line(65, CH_CR);
        take_line();
        take_line();
        discard(13'h1FFF);
        wait_for_results();

        // With a limit of zero the leading terminators still go, but no line is found.
        write_max_line(7'd0);
        push_byte(CH_LF);
        push_byte(CH_CR);
        send_line(2, CH_LF);
        take_line();
        take_line();
        discard(13'h1FFF);
        wait_for_results();

        // A limit of one can never hold a line, as a bare terminator is always dropped.
        write_max_line(7'd1);
        send_line(2, CH_CR);
        take_line();
        discard(13'h1FFF);
        wait_for_results();

        // A line exactly as long as the limit is returned; one byte longer is not.
        write_max_line(7'd2);
        send_line(2, CH_LF);
        take_line();
        send_line(3, CH_CR);
        take_line();
        discard(13'h1FFF);
        wait_for_results();

        // A write to an address with no register behind it must leave max_line alone.
        apb_access(1'b1, ADDR_UNMAPPED, $urandom, rdata);
        check_max_line();
        write_max_line(MAX_LINE_RST);
    endtask

    // Random traffic made mostly of whole lines, over several max_line settings.
    task automatic test_random_traffic();
        logic [LINE_W-1:0] settings [RANDOM_PHASES];
        int                limit;
        int                sent;
        int                len;
        int                r;
        settings = '{7'd64, 7'd1, 7'd9, 7'd127, 7'd20, 7'd0};
        settings[4] = LINE_W'($urandom_range(2, 63));
        foreach (settings[p]) begin
            wait_for_results();
            write_max_line(settings[p]);
            // Each idling pattern is left out in some phase, so gap-free stretches occur too.
            tx_pauses = (p % 3) != 1;
            rx_pauses = (p % 3) != 2;
            limit = (line_max > LINE_LIMIT) ? LINE_LIMIT : line_max;
            sent  = 0;
            while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    len = line_length(limit);
                    send_line(len, pick_terminator());
                    sent += len;
                    if ($urandom_range(0, 3) == 0) begin
                        push_byte(pick_terminator());
                        sent++;
                    end
                end else if (r < 72) begin
                    take_line();
                    sent++;
                end else if (r < 82) begin
                    discard(discard_count());
                    sent++;
                end else if (r < 87) begin
                    send_request(KIND_IGNORE, random_byte(), random_count());
                end else begin
                    push_byte(random_byte());
                    sent++;
                end
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the block
    // fills and has to stall its request channel.
    task automatic test_receiver_hold_off();
        tx_pauses = 1'b0;
        rx_pauses = 1'b1;
        @(posedge i_clk);
        rx_hold = HOLD_OFF_CYCLES;
        repeat (6) begin
            send_line(3, CH_LF);
            take_line();
        end
        while (rx_hold > 0)
            @(posedge i_clk);
        wait_for_results();
    endtask

    // Builds a backlog of bytes with scattered terminators, then drains it with take-line
    // and discard requests, and finishes with fresh lines on the emptied store.
    task automatic test_deep_backlog();
        tx_pauses = 1'b0;
        rx_pauses = 1'b0;
        repeat (48) begin
            if ($urandom_range(0, 11) == 0)
                push_byte(pick_terminator());
            else
                push_byte(ordinary_byte());
        end
        rx_pauses = 1'b1;
        repeat (6) take_line();
        discard(COUNT_W'($urandom_range(5, 20)));
        repeat (3) take_line();
        discard(13'h1FFF);
        // The store is empty now; fresh lines start wherever the front pointer was left.
        repeat (3) begin
            send_line($urandom_range(1, 10), pick_terminator());
            take_line();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_kind     = KIND_PUSH;
        i_data     = '0;
        i_count    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_pauses  = 1'b1;
        rx_pauses  = 1'b1;
        ring_front = 0;
        ring_fill  = 0;
        line_max   = MAX_LINE_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The limit must read back as its reset value before anything is written.
        check_max_line();
        test_directed_requests();
        test_line_length_limits();
        test_random_traffic();
        test_receiver_hold_off();
        test_deep_backlog();
        wait_for_results();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
